/* sv/qbr_pkg.sv */
package qbr_pkg;

    localparam int DATA_W   = 32;
    localparam int TOL_W    = 31;
    localparam int STEPS_W  = 7;
    localparam int STATUS_W = 3;
    localparam int FUNC_W   = 64;

    localparam logic [63:0] TERM_LIMIT = 64'h1000_0000_0000_0000;

    typedef enum logic [1:0] {
        CFG_SQUARE = 2'd0,
        CFG_LINEAR = 2'd1,
        CFG_CONST  = 2'd2,
        CFG_TOL    = 2'd3
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_LOWER  = 3'd0,
        STAT_UPPER  = 3'd1,
        STAT_NOSIGN = 3'd2,
        STAT_CONV   = 3'd3,
        STAT_CAP    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        MUL_XX,
        MUL_LX,
        MUL_SQL,
        MUL_SQH,
        MUL_TOL
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XX,
        ST_XXW,
        ST_T1L,
        ST_T1H,
        ST_T1S,
        ST_SUM,
        ST_FA,
        ST_FB,
        ST_CONV,
        ST_CHK,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_M
    } phase_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     xx_ld;
        logic     t2_ld;
        logic     acc_ld;
        logic     t1_ld;
        logic     f_ld;
        logic     fa_ld;
        logic     x_to_b;
        logic     start_bisect;
        logic     upd;
        logic     publish;
        status_t  status;
    } cmd_t;

    typedef struct packed {
        logic fa_near;
        logic f_near;
        logic same_sign;
        logic conv;
        logic step_last;
    } stat_t;

endpackage

/* sv/qbr_datapath.sv */
module qbr_datapath #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [1:0]                          cfg_index,
    input  logic [qbr_pkg::DATA_W-1:0]          cfg_data,
    input  logic signed [qbr_pkg::DATA_W-1:0]   lower,
    input  logic signed [qbr_pkg::DATA_W-1:0]   upper,
    input  qbr_pkg::cmd_t                       cmd,
    output qbr_pkg::stat_t                      stat,
    output logic signed [qbr_pkg::DATA_W-1:0]   root,
    output logic [qbr_pkg::STATUS_W-1:0]        status,
    output logic [qbr_pkg::STEPS_W-1:0]         steps
);

    localparam int XX_W    = 63 - FRAC_BITS;
    localparam int XX_HI_W = XX_W - 32;
    localparam int PROD_W  = 32 + XX_W;
    localparam int SHIFT_W = PROD_W - FRAC_BITS;
    localparam int CMP_W   = (SHIFT_W > 64) ? SHIFT_W : 64;

    function automatic logic signed [31:0] midpoint(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        s = s + {32'd0, s[32]};
        return s[32:1];
    endfunction

    logic signed [31:0] sq_reg, lin_reg, const_reg;
    logic [qbr_pkg::TOL_W-1:0] tol_reg;

    logic signed [31:0] a_reg, b_reg, x_reg, prev_reg;
    logic [qbr_pkg::STEPS_W-1:0] steps_reg;
    logic [XX_W-1:0] xx_reg;
    logic [63:0] prod_reg, acc_reg;
    logic signed [63:0] t1_reg, t2_reg, f_reg;
    logic fa_pos_reg, fa_neg_reg, fa_near_reg;
    logic signed [31:0] root_reg;
    logic [qbr_pkg::STATUS_W-1:0] status_reg;
    logic [qbr_pkg::STEPS_W-1:0] steps_out_reg;

    logic [31:0] ux, usq, ulin, ma, mb;
    logic [63:0] prod_c;
    logic [63:0] lx_sh;
    logic [PROD_W-1:0] p_full;
    logic [CMP_W-1:0] p_cmp;
    logic [63:0] t1_mag;
    logic f_neg, f_pos, f_near;
    logic [63:0] f_mag;
    logic opposite;
    logic signed [31:0] a_upd, b_upd;
    logic [32:0] d;
    logic [31:0] ud;
    logic [38:0] hundred;
    logic [63:0] lhs;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg    <= 32'sd196608;
            lin_reg   <= 32'sd393216;
            const_reg <= -32'sd262144;
            tol_reg   <= 31'd3277;
        end
        else if (cfg_wr)
        begin
            case (qbr_pkg::cfg_idx_t'(cfg_index))
                qbr_pkg::CFG_SQUARE: sq_reg    <= cfg_data;
                qbr_pkg::CFG_LINEAR: lin_reg   <= cfg_data;
                qbr_pkg::CFG_CONST:  const_reg <= cfg_data;
                qbr_pkg::CFG_TOL:    tol_reg   <= cfg_data[qbr_pkg::TOL_W-1:0];
                default:             tol_reg   <= tol_reg;
            endcase
        end
    end

    assign ux   = x_reg[31]   ? (~x_reg + 32'd1)   : x_reg;
    assign usq  = sq_reg[31]  ? (~sq_reg + 32'd1)  : sq_reg;
    assign ulin = lin_reg[31] ? (~lin_reg + 32'd1) : lin_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            qbr_pkg::MUL_XX:
            begin
                ma = ux;
                mb = ux;
            end
            qbr_pkg::MUL_LX:
            begin
                ma = ulin;
                mb = ux;
            end
            qbr_pkg::MUL_SQL:
            begin
                ma = usq;
                mb = xx_reg[31:0];
            end
            qbr_pkg::MUL_SQH:
            begin
                ma = usq;
                mb = {{(32-XX_HI_W){1'b0}}, xx_reg[XX_W-1:32]};
            end
            qbr_pkg::MUL_TOL:
            begin
                ma = {1'b0, tol_reg};
                mb = ux;
            end
            default:
            begin
                ma = ux;
                mb = ux;
            end
        endcase
    end

    assign prod_c = ma * mb;

    assign lx_sh  = prod_reg >> FRAC_BITS;
    assign p_full = (PROD_W'(prod_reg) << 32) + PROD_W'(acc_reg);
    assign p_cmp  = CMP_W'(p_full >> FRAC_BITS);
    assign t1_mag = (p_cmp > CMP_W'(qbr_pkg::TERM_LIMIT)) ? qbr_pkg::TERM_LIMIT : p_cmp[63:0];

    assign f_neg  = f_reg[63];
    assign f_pos  = !f_reg[63] && (f_reg != 64'sd0);
    assign f_mag  = f_neg ? (~f_reg + 64'd1) : f_reg;
    assign f_near = f_mag < {33'd0, tol_reg};

    assign opposite = (fa_pos_reg && f_neg) || (fa_neg_reg && f_pos);
    assign a_upd    = opposite ? a_reg : x_reg;
    assign b_upd    = opposite ? x_reg : b_reg;

    // convergence: |m - prev| * 100 * 2^F < tol * |m|
    assign d       = {x_reg[31], x_reg} - {prev_reg[31], prev_reg};
    assign ud      = d[32] ? 32'(~d + 33'd1) : d[31:0];
    assign hundred = ({7'd0, ud} << 6) + ({7'd0, ud} << 5) + ({7'd0, ud} << 2);
    assign lhs     = 64'(hundred) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_c;
        if (cmd.xx_ld)
        begin
            xx_reg <= XX_W'(prod_reg >> FRAC_BITS);
        end
        if (cmd.t2_ld)
        begin
            t2_reg <= (lin_reg[31] ^ x_reg[31]) ? -$signed(lx_sh) : $signed(lx_sh);
        end
        if (cmd.acc_ld)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.t1_ld)
        begin
            t1_reg <= sq_reg[31] ? -$signed(t1_mag) : $signed(t1_mag);
        end
        if (cmd.f_ld)
        begin
            f_reg <= t1_reg + t2_reg + $signed({{32{const_reg[31]}}, const_reg});
        end
        if (cmd.fa_ld || (cmd.upd && !opposite))
        begin
            fa_pos_reg  <= f_pos;
            fa_neg_reg  <= f_neg;
            fa_near_reg <= f_near;
        end

        if (cmd.load)
        begin
            a_reg     <= lower;
            b_reg     <= upper;
            x_reg     <= lower;
            steps_reg <= '0;
        end
        else if (cmd.x_to_b)
        begin
            x_reg <= b_reg;
        end
        else if (cmd.start_bisect)
        begin
            x_reg     <= midpoint(a_reg, b_reg);
            prev_reg  <= '0;
            steps_reg <= qbr_pkg::STEPS_W'(1);
        end
        else if (cmd.upd)
        begin
            a_reg     <= a_upd;
            b_reg     <= b_upd;
            prev_reg  <= x_reg;
            x_reg     <= midpoint(a_upd, b_upd);
            steps_reg <= steps_reg + qbr_pkg::STEPS_W'(1);
        end

        if (cmd.publish)
        begin
            case (cmd.status)
                qbr_pkg::STAT_LOWER:  root_reg <= a_reg;
                qbr_pkg::STAT_UPPER:  root_reg <= b_reg;
                qbr_pkg::STAT_NOSIGN: root_reg <= '0;
                default:              root_reg <= x_reg;
            endcase
            status_reg    <= cmd.status;
            steps_out_reg <= steps_reg;
        end
    end

    assign stat.fa_near   = fa_near_reg;
    assign stat.f_near    = f_near;
    assign stat.same_sign = (fa_pos_reg && f_pos) || (fa_neg_reg && f_neg);
    assign stat.conv      = lhs < prod_reg;
    assign stat.step_last = steps_reg == qbr_pkg::STEPS_W'(MAX_STEPS);

    assign root   = root_reg;
    assign status = status_reg;
    assign steps  = steps_out_reg;

endmodule

/* sv/qbr_ctrl.sv */
module qbr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  qbr_pkg::stat_t stat,
    output qbr_pkg::cmd_t  cmd
);

    qbr_pkg::state_t  state_reg, state_next;
    qbr_pkg::phase_t  phase_reg, phase_next;
    qbr_pkg::status_t fin_reg, fin_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qbr_pkg::ST_IDLE;
            phase_reg     <= qbr_pkg::PH_A;
            fin_reg       <= qbr_pkg::STAT_LOWER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            qbr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = qbr_pkg::ST_XX;
                    phase_next = qbr_pkg::PH_A;
                end
            end
            qbr_pkg::ST_XX:  state_next = qbr_pkg::ST_XXW;
            qbr_pkg::ST_XXW: state_next = qbr_pkg::ST_T1L;
            qbr_pkg::ST_T1L: state_next = qbr_pkg::ST_T1H;
            qbr_pkg::ST_T1H: state_next = qbr_pkg::ST_T1S;
            qbr_pkg::ST_T1S: state_next = qbr_pkg::ST_SUM;
            qbr_pkg::ST_SUM:
            begin
                case (phase_reg)
                    qbr_pkg::PH_A: state_next = qbr_pkg::ST_FA;
                    qbr_pkg::PH_B: state_next = qbr_pkg::ST_FB;
                    default:       state_next = qbr_pkg::ST_UPD;
                endcase
            end
            qbr_pkg::ST_FA:
            begin
                state_next = qbr_pkg::ST_XX;
                phase_next = qbr_pkg::PH_B;
            end
            qbr_pkg::ST_FB:
            begin
                if (stat.fa_near)
                begin
                    fin_next   = qbr_pkg::STAT_LOWER;
                    state_next = qbr_pkg::ST_DONE;
                end
                else if (stat.f_near)
                begin
                    fin_next   = qbr_pkg::STAT_UPPER;
                    state_next = qbr_pkg::ST_DONE;
                end
                else if (stat.same_sign)
                begin
                    fin_next   = qbr_pkg::STAT_NOSIGN;
                    state_next = qbr_pkg::ST_DONE;
                end
                else
                begin
                    phase_next = qbr_pkg::PH_M;
                    state_next = qbr_pkg::ST_CONV;
                end
            end
            qbr_pkg::ST_CONV: state_next = qbr_pkg::ST_CHK;
            qbr_pkg::ST_CHK:
            begin
                if (stat.conv)
                begin
                    fin_next   = qbr_pkg::STAT_CONV;
                    state_next = qbr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = qbr_pkg::ST_XXW;
                end
            end
            qbr_pkg::ST_UPD:
            begin
                if (stat.step_last)
                begin
                    fin_next   = qbr_pkg::STAT_CAP;
                    state_next = qbr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = qbr_pkg::ST_CONV;
                end
            end
            qbr_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = qbr_pkg::ST_IDLE;
                end
            end
            default: state_next = qbr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd              = '0;
        cmd.mul_sel      = qbr_pkg::MUL_XX;
        cmd.status       = fin_reg;
        in_ready         = 1'b0;
        case (state_reg)
            qbr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            qbr_pkg::ST_XX: cmd.mul_sel = qbr_pkg::MUL_XX;
            qbr_pkg::ST_XXW:
            begin
                cmd.xx_ld   = 1'b1;
                cmd.mul_sel = qbr_pkg::MUL_LX;
            end
            qbr_pkg::ST_T1L:
            begin
                cmd.t2_ld   = 1'b1;
                cmd.mul_sel = qbr_pkg::MUL_SQL;
            end
            qbr_pkg::ST_T1H:
            begin
                cmd.acc_ld  = 1'b1;
                cmd.mul_sel = qbr_pkg::MUL_SQH;
            end
            qbr_pkg::ST_T1S: cmd.t1_ld = 1'b1;
            qbr_pkg::ST_SUM: cmd.f_ld  = 1'b1;
            qbr_pkg::ST_FA:
            begin
                cmd.fa_ld  = 1'b1;
                cmd.x_to_b = 1'b1;
            end
            qbr_pkg::ST_FB:
            begin
                cmd.start_bisect = !stat.fa_near && !stat.f_near && !stat.same_sign;
            end
            qbr_pkg::ST_CONV: cmd.mul_sel = qbr_pkg::MUL_TOL;
            qbr_pkg::ST_CHK:  cmd.mul_sel = qbr_pkg::MUL_XX;
            qbr_pkg::ST_UPD:  cmd.upd     = !stat.step_last;
            qbr_pkg::ST_DONE: cmd.publish = slot_free;
            default:          cmd.load    = 1'b0;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/quadratic_bisection_root_unit.sv */
// channel  dir  handshake            fields                 transaction
// in       in   in_valid/in_ready    lower, upper           one search interval
// out      out  out_valid/out_ready  root, status, steps    one result
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data    one register write
//
// One shared 32x32 multiplier sets the pace: the unit evaluates both endpoints, then
// each halving takes five more products. A search ends with an endpoint or no-root
// result, on convergence, or at the step cap of MAX_STEPS (64 by default).
// One item in flight; in_ready is high only while idle. A finished result waits in
// DONE only while the output register is still full. cfg_ready is always high.
// Reset is asynchronous: config registers return to 3.0, 6.0, -4.0 and 0.05.
module quadratic_bisection_root_unit #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qbr_pkg::DATA_W-1:0]   lower,
    input  logic signed [qbr_pkg::DATA_W-1:0]   upper,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qbr_pkg::DATA_W-1:0]   root,
    output logic [qbr_pkg::STATUS_W-1:0]        status,
    output logic [qbr_pkg::STEPS_W-1:0]         steps,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [qbr_pkg::DATA_W-1:0]          cfg_data
);

    qbr_pkg::cmd_t  cmd;
    qbr_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    qbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    qbr_datapath #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lower     (lower),
        .upper     (upper),
        .cmd       (cmd),
        .stat      (stat),
        .root      (root),
        .status    (status),
        .steps     (steps)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a search is running");

    a_publish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid || out_ready))
        else $error("result overwrites an untaken result");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> steps <= qbr_pkg::STEPS_W'(MAX_STEPS))
        else $error("step count beyond cap");

    a_early_exit_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == qbr_pkg::STAT_LOWER || status == qbr_pkg::STAT_UPPER
            || status == qbr_pkg::STAT_NOSIGN) |-> steps == '0)
        else $error("endpoint or no-root result with nonzero steps");

endmodule
